// ===== src/pcqm_pkg.sv =====
// Shared types and constants for the pedal cadence quadrature meter.
// No dependencies; imported by every module of the block but pcqm_fifo.
package pcqm_pkg;

  localparam int MAG_W   = 7;
  localparam int MINP_W  = 32;
  localparam int IDLE_W  = 16;
  localparam int SCALE_W = 32;
  localparam int CAD_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGNET_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDLE_SAMPLES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DIRECTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE        = 3'd4;

  localparam logic [MAG_W-1:0]   MAG_RST   = 7'd1;
  localparam logic [MINP_W-1:0]  MINP_RST  = 32'd1;
  localparam logic [IDLE_W-1:0]  IDLE_RST  = 16'hFFFF;
  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd9600000;

  localparam logic [CAD_W-1:0] CAD_POS_MAX = 16'h7FFF;
  localparam logic [CAD_W-1:0] CAD_NEG_MAX = 16'h8000;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2,
    DIR_BAD  = 2'd3
  } dir_t;

  typedef struct packed {
    logic is_edge;
    dir_t dir;
  } cmd_t;

  function automatic dir_t dir_lookup(input logic [3:0] idx);
    dir_t d;
    unique case (idx)
      4'd0, 4'd5, 4'd10, 4'd15: d = DIR_NONE;
      4'd2, 4'd4, 4'd11, 4'd13: d = DIR_FWD;
      4'd1, 4'd7, 4'd8,  4'd14: d = DIR_REV;
      default:                  d = DIR_BAD;
    endcase
    return d;
  endfunction

endpackage

// ===== src/pedal_cadence_quadrature_meter_core.sv =====
// Top level of the pedal cadence quadrature meter: config registers and wiring.
// Depends on pcqm_pkg, pcqm_front, pcqm_fifo and pcqm_back.
//
//   channel  handshake         payload
//   in       in_push/in_full   in_sensor_a_level, in_sensor_b_level, in_time_stamp
//   out      out_pop/out_empty out_cadence
//   cfg      cfg_we            cfg_index, cfg_data
//
// A sample with both sensors high and an accepted period of at most 32 bits goes
// through ST_IDLE, ST_CHECK, ST_DIV (waiting on the bit-serial divider), ST_FORM
// and ST_OUT; other samples skip ST_DIV, and only wider periods visit ST_FORM.
// The front accepts while the two-entry command queue has room, so samples
// arrive while the back end divides or a result waits to be popped.
// rst_n is synchronous; reset loads the register defaults and clears the control state.
module pedal_cadence_quadrature_meter_core #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_sensor_a_level,
  input  logic                                 in_sensor_b_level,
  input  logic [TIME_WIDTH-1:0]                in_time_stamp,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [pcqm_pkg::CAD_W-1:0]    out_cadence,
  input  logic                                 cfg_we,
  input  logic [pcqm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcqm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pcqm_pkg::*;

  localparam int PW = TIME_WIDTH + MAG_W;
  localparam int CMD_W = $bits(cmd_t);
  localparam int QW = CMD_W + PW;

  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [MINP_W-1:0]  minp_r, minp_nxt;
  logic [IDLE_W-1:0]  max_idle_r, max_idle_nxt;
  logic               invert_r, invert_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;

  logic          q_push, q_full, q_pop, q_empty;
  cmd_t          f_cmd, b_cmd;
  logic [PW-1:0] f_period, b_period;
  logic [QW-1:0] q_wdata, q_rdata;

  always_comb begin
    mag_nxt      = mag_r;
    minp_nxt     = minp_r;
    max_idle_nxt = max_idle_r;
    invert_nxt   = invert_r;
    scale_nxt    = scale_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGNET_COUNT:     mag_nxt      = cfg_data[MAG_W-1:0];
        CFG_MIN_PERIOD_TICKS: minp_nxt     = cfg_data[MINP_W-1:0];
        CFG_MAX_IDLE_SAMPLES: max_idle_nxt = cfg_data[IDLE_W-1:0];
        CFG_INVERT_DIRECTION: invert_nxt   = cfg_data[0];
        CFG_RPM_SCALE:        scale_nxt    = cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r      <= MAG_RST;
      minp_r     <= MINP_RST;
      max_idle_r <= IDLE_RST;
      invert_r   <= 1'b0;
      scale_r    <= SCALE_RST;
    end else begin
      mag_r      <= mag_nxt;
      minp_r     <= minp_nxt;
      max_idle_r <= max_idle_nxt;
      invert_r   <= invert_nxt;
      scale_r    <= scale_nxt;
    end
  end

  pcqm_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_sensor_a_level (in_sensor_a_level),
    .in_sensor_b_level (in_sensor_b_level),
    .in_time_stamp     (in_time_stamp),
    .in_full           (in_full),
    .magnet_count      (mag_r),
    .fifo_full         (q_full),
    .fifo_push         (q_push),
    .cmd               (f_cmd),
    .period            (f_period)
  );

  assign q_wdata  = {f_cmd, f_period};
  assign b_cmd    = cmd_t'(q_rdata[QW-1:PW]);
  assign b_period = q_rdata[PW-1:0];

  pcqm_fifo #(
    .DW    (QW),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  pcqm_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_empty       (q_empty),
    .fifo_pop         (q_pop),
    .cmd              (b_cmd),
    .period           (b_period),
    .min_period_ticks (minp_r),
    .max_idle_samples (max_idle_r),
    .invert_direction (invert_r),
    .rpm_scale        (scale_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_cadence      (out_cadence)
  );

endmodule

// ===== src/pcqm_front.sv =====
// Front end: accepts sensor samples, classifies transitions, forms the period.
// Depends on pcqm_pkg.
module pcqm_front #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  logic                                 in_sensor_a_level,
  input  logic                                 in_sensor_b_level,
  input  logic [TIME_WIDTH-1:0]                in_time_stamp,
  output logic                                 in_full,
  input  logic [pcqm_pkg::MAG_W-1:0]           magnet_count,
  input  logic                                 fifo_full,
  output logic                                 fifo_push,
  output pcqm_pkg::cmd_t                       cmd,
  output logic [TIME_WIDTH+pcqm_pkg::MAG_W-1:0] period
);
  import pcqm_pkg::*;

  localparam int PW = TIME_WIDTH + MAG_W;

  logic [1:0]            prev_state_r, prev_state_nxt;
  logic [TIME_WIDTH-1:0] prev_time_r, prev_time_nxt;
  logic [1:0]            smp_state;
  logic [TIME_WIDTH-1:0] diff;
  logic                  accept;

  assign accept    = in_push & ~fifo_full;
  assign in_full   = fifo_full;
  assign fifo_push = accept;
  assign smp_state = {in_sensor_b_level, in_sensor_a_level};
  assign diff      = in_time_stamp - prev_time_r;

  always_comb begin
    cmd.is_edge = (smp_state == 2'b11);
    cmd.dir     = dir_lookup({prev_state_r, smp_state});
    period      = PW'(diff) * PW'(magnet_count);
    prev_state_nxt = prev_state_r;
    prev_time_nxt  = prev_time_r;
    if (accept) begin
      prev_state_nxt = smp_state;
      if (cmd.is_edge) begin
        prev_time_nxt = in_time_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_state_r <= '0;
      prev_time_r  <= '0;
    end else begin
      prev_state_r <= prev_state_nxt;
      prev_time_r  <= prev_time_nxt;
    end
  end

endmodule

// ===== src/pcqm_fifo.sv =====
// Short command queue between the front and back ends.
// Generic width and depth; no package dependency.
module pcqm_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/pcqm_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit operands.
// Depends on pcqm_pkg for the operand width.
module pcqm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcqm_pkg::SCALE_W-1:0] dividend,
  input  logic [pcqm_pkg::SCALE_W-1:0] divisor,
  output logic                        done,
  output logic [pcqm_pkg::SCALE_W-1:0] quotient
);
  import pcqm_pkg::*;

  localparam int NW = $clog2(SCALE_W);

  logic [SCALE_W-1:0] rem_r, rem_nxt;
  logic [SCALE_W-1:0] quo_r, quo_nxt;
  logic [SCALE_W-1:0] div_r, div_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [SCALE_W:0]   trial;
  logic               ge;

  assign trial    = {rem_r, quo_r[SCALE_W-1]};
  assign ge       = (trial >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? SCALE_W'(trial - {1'b0, div_r}) : trial[SCALE_W-1:0];
      quo_nxt = {quo_r[SCALE_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == NW'(SCALE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// ===== src/pcqm_back.sv =====
// Back end: executes queued commands, divides, saturates, holds the result.
// Depends on pcqm_pkg and pcqm_div.
module pcqm_back #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fifo_empty,
  output logic                                  fifo_pop,
  input  pcqm_pkg::cmd_t                        cmd,
  input  logic [TIME_WIDTH+pcqm_pkg::MAG_W-1:0] period,
  input  logic [pcqm_pkg::MINP_W-1:0]           min_period_ticks,
  input  logic [pcqm_pkg::IDLE_W-1:0]           max_idle_samples,
  input  logic                                  invert_direction,
  input  logic [pcqm_pkg::SCALE_W-1:0]          rpm_scale,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [pcqm_pkg::CAD_W-1:0]     out_cadence
);
  import pcqm_pkg::*;

  localparam int PW = TIME_WIDTH + MAG_W;
  localparam int EW = (PW > SCALE_W) ? PW : SCALE_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_FORM  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [PW-1:0]      period_r, period_nxt;
  logic               big_r, big_nxt;
  logic [CAD_W-1:0]   cadence_r, cadence_nxt;
  logic [IDLE_W-1:0]  idle_r, idle_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CAD_W-1:0]   out_cad_r, out_cad_nxt;

  logic [EW-1:0]      period_ext;
  logic               big, period_ok;
  logic [IDLE_W-1:0]  idle_inc;
  logic               div_start, div_done;
  logic [SCALE_W-1:0] div_q, q;
  logic [SCALE_W:0]   mag;
  logic               neg;
  logic [CAD_W-1:0]   formed;

  pcqm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rpm_scale),
    .divisor  (period_ext[SCALE_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign period_ext  = EW'(period_r);
  assign big         = |period_ext[EW-1:SCALE_W];
  assign period_ok   = (period_ext != '0) && (period_ext >= EW'(min_period_ticks));
  assign idle_inc    = (idle_r == '1) ? idle_r : idle_r + 1'b1;
  assign out_empty   = ~out_valid_r;
  assign out_cadence = out_cad_r;

  always_comb begin
    q   = big_r ? '0 : div_q;
    mag = (cmd_r.dir == DIR_BAD) ? {q, 1'b0} : {1'b0, q};
    neg = (cmd_r.dir == DIR_REV) ^ invert_direction;
    if (cmd_r.dir == DIR_NONE) begin
      formed = '0;
    end else if (neg) begin
      formed = (mag > (SCALE_W + 1)'(CAD_NEG_MAX)) ? CAD_NEG_MAX : CAD_W'(-mag);
    end else begin
      formed = (mag > (SCALE_W + 1)'(CAD_POS_MAX)) ? CAD_POS_MAX : mag[CAD_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    period_nxt    = period_r;
    big_nxt       = big_r;
    cadence_nxt   = cadence_r;
    idle_nxt      = idle_r;
    out_valid_nxt = out_valid_r;
    out_cad_nxt   = out_cad_r;
    fifo_pop      = 1'b0;
    div_start     = 1'b0;
    if (out_valid_r && out_pop) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop   = 1'b1;
          cmd_nxt    = cmd;
          period_nxt = period;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!cmd_r.is_edge) begin
          idle_nxt = idle_inc;
          if (idle_inc > max_idle_samples) begin
            cadence_nxt = '0;
          end
          state_nxt = ST_OUT;
        end else if (!period_ok) begin
          state_nxt = ST_OUT;
        end else if (big) begin
          big_nxt   = 1'b1;
          state_nxt = ST_FORM;
        end else begin
          big_nxt   = 1'b0;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FORM;
        end
      end
      ST_FORM: begin
        cadence_nxt = formed;
        idle_nxt    = '0;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_cad_nxt   = cadence_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    period_r  <= period_nxt;
    big_r     <= big_nxt;
    out_cad_r <= out_cad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cadence_r   <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cadence_r   <= cadence_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for pedal_cadence_quadrature_meter_core, needs pcqm_pkg and the core RTL.
// Drives sensor samples and register writes, predicts each cadence, and checks every popped one.
module tb_top;
  import pcqm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int MAX_REPORTS    = 10;

  logic                    clk;
  logic                    rst_n;
  logic                    in_push;
  logic                    in_full;
  logic                    in_sensor_a_level;
  logic                    in_sensor_b_level;
  logic [31:0]             in_time_stamp;
  logic                    out_empty;
  logic                    out_pop;
  logic signed [CAD_W-1:0] out_cadence;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  logic [MAG_W-1:0]   mdl_magnet;
  logic [MINP_W-1:0]  mdl_min_period;
  logic [IDLE_W-1:0]  mdl_max_idle;
  logic               mdl_invert;
  logic [SCALE_W-1:0] mdl_scale;
  logic [1:0]         mdl_state;
  logic [31:0]        mdl_edge_time;
  logic [IDLE_W-1:0]  mdl_idle;
  logic [CAD_W-1:0]   mdl_cadence;

  logic [CAD_W-1:0] cadence_q[$];
  int unsigned      fail_count;
  int unsigned      quiet_cycles;
  bit               push_steady;
  bit               pop_steady;

  pedal_cadence_quadrature_meter_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_sensor_a_level (in_sensor_a_level),
    .in_sensor_b_level (in_sensor_b_level),
    .in_time_stamp     (in_time_stamp),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_cadence       (out_cadence),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [1:0] next_quad_state(input logic [1:0] cur, input logic fwd);
    logic [1:0] nxt;
    if (fwd) begin
      case (cur)
        2'd0:    nxt = 2'd2;
        2'd2:    nxt = 2'd3;
        2'd3:    nxt = 2'd1;
        default: nxt = 2'd0;
      endcase
    end else begin
      case (cur)
        2'd0:    nxt = 2'd1;
        2'd1:    nxt = 2'd3;
        2'd3:    nxt = 2'd2;
        default: nxt = 2'd0;
      endcase
    end
    return nxt;
  endfunction

  function automatic logic [CAD_W-1:0] predict_cadence(input logic [1:0] now_state,
                                                       input logic [31:0] now_ts);
    dir_t        dir;
    logic [31:0] gap;
    logic [63:0] span;
    logic [63:0] quo;
    logic [63:0] mag;
    logic        neg;
    if (now_state == mdl_state) dir = DIR_NONE;
    else if (now_state == next_quad_state(mdl_state, 1'b1)) dir = DIR_FWD;
    else if (now_state == next_quad_state(mdl_state, 1'b0)) dir = DIR_REV;
    else dir = DIR_BAD;
    mdl_state = now_state;
    if (now_state == 2'd3) begin
      gap = now_ts - mdl_edge_time;
      span = {32'd0, gap} * {57'd0, mdl_magnet};
      mdl_edge_time = now_ts;
      if (span != 64'd0 && span >= {32'd0, mdl_min_period}) begin
        quo = {32'd0, mdl_scale} / span;
        mdl_idle = '0;
        if (dir == DIR_NONE) begin
          mdl_cadence = '0;
        end else begin
          mag = (dir == DIR_BAD) ? (quo << 1) : quo;
          neg = (dir == DIR_REV) ^ mdl_invert;
          if (neg) begin
            if (mag > 64'd32768) mag = 64'd32768;
            mdl_cadence = 16'd0 - mag[15:0];
          end else begin
            if (mag > 64'd32767) mag = 64'd32767;
            mdl_cadence = mag[15:0];
          end
        end
      end
    end else begin
      if (mdl_idle != 16'hFFFF) mdl_idle = mdl_idle + 16'd1;
      if (mdl_idle > mdl_max_idle) mdl_cadence = '0;
    end
    return mdl_cadence;
  endfunction

  task automatic send_sample(input logic [1:0] st, input logic [31:0] ts);
    @(negedge clk);
    while (!push_steady && $urandom_range(99) < 13) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push           <= 1'b1;
    in_sensor_a_level <= st[0];
    in_sensor_b_level <= st[1];
    in_time_stamp     <= ts;
    @(posedge clk);
    while (in_full) @(posedge clk);
    cadence_q.push_back(predict_cadence(st, ts));
  endtask

  // drop the input, wait for every cadence, then let the block go quiet
  task automatic settle_block();
    @(negedge clk);
    in_push <= 1'b0;
    while (cadence_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MAGNET_COUNT:     mdl_magnet     = val[MAG_W-1:0];
      CFG_MIN_PERIOD_TICKS: mdl_min_period = val[MINP_W-1:0];
      CFG_MAX_IDLE_SAMPLES: mdl_max_idle   = val[IDLE_W-1:0];
      CFG_INVERT_DIRECTION: mdl_invert     = val[0];
      CFG_RPM_SCALE:        mdl_scale      = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_quadrature_basics();
    send_sample(2'd0, 32'd0);
    send_sample(2'd2, 32'd100);
    send_sample(2'd3, 32'd1000);
    send_sample(2'd1, 32'd1200);
    send_sample(2'd0, 32'd1300);
    send_sample(2'd1, 32'd1350);
    send_sample(2'd3, 32'd1001);
    send_sample(2'd3, 32'd1001);
    send_sample(2'd3, 32'hFFFF_FFFF);
    send_sample(2'd0, 32'd5);
    send_sample(2'd3, 32'h0000_0010);
  endtask

  task automatic test_register_extremes();
    settle_block();
    write_reg(CFG_MAGNET_COUNT, 32'd0);
    send_sample(2'd1, 32'h20);
    send_sample(2'd3, 32'h500);
    settle_block();
    write_reg(CFG_MAGNET_COUNT, 32'd127);
    write_reg(CFG_MIN_PERIOD_TICKS, 32'hFFFF_FFFF);
    send_sample(2'd2, 32'h600);
    send_sample(2'd3, 32'h9E8);
    settle_block();
    write_reg(CFG_MIN_PERIOD_TICKS, 32'd1);
    write_reg(CFG_RPM_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_INVERT_DIRECTION, 32'd1);
    send_sample(2'd1, 32'h1000);
    send_sample(2'd3, 32'h1000 + 32'd200000);
    settle_block();
    write_reg(CFG_MAX_IDLE_SAMPLES, 32'd0);
    write_reg(CFG_RPM_SCALE, 32'd1);
    send_sample(2'd2, 32'h5_0000);
    send_sample(2'd3, 32'h5_0001);
  endtask

  task automatic test_idle_saturation();
    int unsigned k;
    settle_block();
    write_reg(CFG_MAGNET_COUNT, {25'd0, MAG_RST});
    write_reg(CFG_MIN_PERIOD_TICKS, MINP_RST);
    write_reg(CFG_MAX_IDLE_SAMPLES, {16'd0, IDLE_RST});
    write_reg(CFG_INVERT_DIRECTION, 32'd0);
    write_reg(CFG_RPM_SCALE, SCALE_RST);
    push_steady = 1'b1;
    pop_steady  = 1'b1;
    send_sample(2'd2, 32'd7000);
    send_sample(2'd3, 32'd9000);
    for (k = 0; k < 32; k++) send_sample(2'd0, 32'd9100);
    settle_block();
    write_reg(CFG_MAX_IDLE_SAMPLES, 32'd31);
    send_sample(2'd0, 32'd9200);
    push_steady = 1'b0;
    pop_steady  = 1'b0;
  endtask

  task automatic test_random_phases();
    int unsigned p, k, run_left, base;
    logic [1:0]  st;
    logic [31:0] ts;
    logic        fwd;
    st = 2'd0;
    ts = $urandom;
    run_left = 0;
    fwd = 1'b1;
    base = 100;
    for (p = 0; p < 8; p++) begin
      settle_block();
      push_steady = (p == 3);
      pop_steady  = (p == 3);
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_MAGNET_COUNT, 32'd0);
        1:       write_reg(CFG_MAGNET_COUNT, $urandom_range(65, 127));
        default: write_reg(CFG_MAGNET_COUNT, $urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_MIN_PERIOD_TICKS, 32'd0);
        1:       write_reg(CFG_MIN_PERIOD_TICKS, 32'hFFFF_FFFF);
        2:       write_reg(CFG_MIN_PERIOD_TICKS, $urandom);
        default: write_reg(CFG_MIN_PERIOD_TICKS, $urandom_range(1, 2000));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_MAX_IDLE_SAMPLES, 32'd65535);
        1:       write_reg(CFG_MAX_IDLE_SAMPLES, $urandom);
        default: write_reg(CFG_MAX_IDLE_SAMPLES, $urandom_range(0, 30));
      endcase
      write_reg(CFG_INVERT_DIRECTION, $urandom);
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_RPM_SCALE, 32'd0);
        1:       write_reg(CFG_RPM_SCALE, 32'hFFFF_FFFF);
        2, 3:    write_reg(CFG_RPM_SCALE, $urandom);
        4:       write_reg(CFG_RPM_SCALE, $urandom_range(1, 1000));
        default: write_reg(CFG_RPM_SCALE, SCALE_RST);
      endcase
      for (k = 0; k < 100; k++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(4, 40);
          fwd = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 3))
            0:       base = $urandom_range(1, 50);
            1:       base = $urandom_range(50, 2000);
            2:       base = $urandom_range(2000, 100000);
            default: base = $urandom_range(0, 3);
          endcase
        end
        run_left--;
        if ($urandom_range(99) < 20) begin
          st = 2'($urandom_range(0, 3));
          if ($urandom_range(0, 1)) ts = $urandom;
          else ts = ts + $urandom_range(0, 50);
        end else begin
          if ($urandom_range(99) >= 15) st = next_quad_state(st, fwd);
          ts = ts + base + $urandom_range(0, base / 8);
        end
        send_sample(st, ts);
      end
    end
    push_steady = 1'b0;
    pop_steady  = 1'b0;
  endtask

  always @(negedge clk) out_pop <= pop_steady || ($urandom_range(99) >= 13);

  always @(posedge clk) begin : check_cadence
    logic [CAD_W-1:0] want;
    if (rst_n && out_pop && !out_empty) begin
      if (cadence_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected cadence transaction: got %0d", out_cadence);
      end else begin
        want = cadence_q.pop_front();
        if (out_cadence !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("cadence mismatch: expected %0d, got %0d", $signed(want), out_cadence);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_push           = 1'b0;
    in_sensor_a_level = 1'b0;
    in_sensor_b_level = 1'b0;
    in_time_stamp     = '0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    push_steady       = 1'b0;
    pop_steady        = 1'b0;
    mdl_magnet        = MAG_RST;
    mdl_min_period    = MINP_RST;
    mdl_max_idle      = IDLE_RST;
    mdl_invert        = 1'b0;
    mdl_scale         = SCALE_RST;
    mdl_state         = '0;
    mdl_edge_time     = '0;
    mdl_idle          = '0;
    mdl_cadence       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_quadrature_basics();
    test_register_extremes();
    test_idle_saturation();
    test_random_phases();

    settle_block();
    if (fail_count == 0 && cadence_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
